FILE: rtl/pstr_pkg.sv
// ----------------------------------------------------------------------------
// pstr_pkg
// Shared types and constants for the scope trace renderer: field widths,
// operation and register codes, sequencer states and the pixel unit control.
// ----------------------------------------------------------------------------
package pstr_pkg;

    // default screen size
    localparam int DEF_WIDTH  = 320;
    localparam int DEF_HEIGHT = 240;

    // payload field widths
    localparam int OP_W       = 2;
    localparam int SAMPLE_W   = 16;
    localparam int RCOL_W     = 9;
    localparam int RROW_W     = 8;
    localparam int PIX_W      = 8;
    localparam int CH_W       = 8;
    localparam int PIXEL_W    = 2 * CH_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // a Q1.15 sample times HEIGHT/4 is the product shifted right by 17
    localparam int Q_SHIFT    = 17;

    // reset value of both intensity registers
    localparam logic [CH_W-1:0] INTENSITY_RST = 8'hff;

    typedef enum logic [OP_W-1:0] {
        OP_DRAW = 2'd0,
        OP_FADE = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTENSITY_A = 1'd0,
        REG_INTENSITY_B = 1'd1
    } reg_idx_t;

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_ROW    = 10'b00_0000_0100,
        ST_SETUP  = 10'b00_0000_1000,
        ST_RD     = 10'b00_0001_0000,
        ST_WR     = 10'b00_0010_0000,
        ST_LOOKUP = 10'b00_0100_0000,
        ST_RDATA  = 10'b00_1000_0000,
        ST_SPARE0 = 10'b01_0000_0000,
        ST_SPARE1 = 10'b10_0000_0000
    } state_t;

    // control of the shared pixel unit
    typedef struct packed {
        logic            fade;
        logic [CH_W-1:0] add_a;
        logic [CH_W-1:0] add_b;
    } pixel_op_t;

endpackage

FILE: rtl/persistence_scope_trace_renderer.sv
// Sequence: draw finds the line ends, then updates each row (none past the right
//   edge); fade updates every entry; read waits for a free output register.
// Throughput: one item at a time; each pixel is a read-modify-write on the single
//   framebuffer port, so the pixel count sets the rate.
// Reset: synchronous active-low aresetn; afterwards a clearing pass writes zero
//   to all WIDTH*HEIGHT entries, one a cycle, before the first item is taken.
// ----------------------------------------------------------------------------
// persistence_scope_trace_renderer
// Scope trace renderer over a two-channel intensity framebuffer with
// vertical line drawing, whole-screen fade and single pixel read.
// ----------------------------------------------------------------------------
module persistence_scope_trace_renderer #(
    parameter int WIDTH  = pstr_pkg::DEF_WIDTH,
    parameter int HEIGHT = pstr_pkg::DEF_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [pstr_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pstr_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pstr_pkg::OP_W-1:0]           s_operation,
    input  logic signed [pstr_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_frame_start,
    input  logic [pstr_pkg::RCOL_W-1:0]         s_read_column,
    input  logic [pstr_pkg::RROW_W-1:0]         s_read_row,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pstr_pkg::PIX_W-1:0]          m_pixel_value
);

    localparam int FB_DEPTH = WIDTH * HEIGHT;
    localparam int ADDR_W   = $clog2(FB_DEPTH);
    localparam int ROW_W    = $clog2(HEIGHT);
    localparam int COL_W    = $clog2(WIDTH + 1);
    localparam int PROD_W   = pstr_pkg::SAMPLE_W + $clog2(HEIGHT + 1) + 1;
    localparam int PIXEL_W  = pstr_pkg::PIXEL_W;
    localparam int CH_W     = pstr_pkg::CH_W;

    localparam logic signed [PROD_W-1:0] HEIGHT_S  = PROD_W'(HEIGHT);
    localparam logic signed [PROD_W-1:0] CENTER_S  = PROD_W'(HEIGHT / 2);
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS =
        PROD_W'((1 << pstr_pkg::Q_SHIFT) - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FB_DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(WIDTH);

    pstr_pkg::state_t state_reg;

    logic [CH_W-1:0]          intensity_a_reg, intensity_b_reg;
    logic [COL_W-1:0]         col_reg, draw_col_reg;
    logic [ROW_W-1:0]         prev_row_reg, cur_row_reg, end_row_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic                     fade_reg, frame_start_reg, in_range_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PIXEL_W-1:0]       rdata_reg;
    logic                     m_valid_reg;
    logic [pstr_pkg::PIX_W-1:0] m_pixel_value_reg;
    logic [PIXEL_W-1:0]       fb_mem_reg [FB_DEPTH];

    logic signed [PROD_W-1:0] prod_biased, prod_quot, row_full;
    logic [ROW_W-1:0]         row_next, prev_eff;
    logic [COL_W-1:0]         col_eff;
    logic                     read_in_range;
    logic                     mem_we, mem_re;
    logic [PIXEL_W-1:0]       mem_wdata, alu_out;
    pstr_pkg::pixel_op_t      alu_op;

    assign s_ready       = (state_reg == pstr_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_pixel_value = m_pixel_value_reg;

    // sample to row: truncating divide by 2^17, then center offset
    assign prod_biased = prod_reg + (prod_reg[PROD_W-1] ? TRUNC_BIAS : '0);
    assign prod_quot   = prod_biased >>> pstr_pkg::Q_SHIFT;
    assign row_full    = prod_quot + CENTER_S;
    assign row_next    = row_full[ROW_W-1:0];
    assign prev_eff    = frame_start_reg ? row_next : prev_row_reg;
    assign col_eff     = frame_start_reg ? '0 : col_reg;

    assign read_in_range = (32'(s_read_column) < WIDTH) && (32'(s_read_row) < HEIGHT);

    // shared pixel unit
    assign alu_op = '{fade: fade_reg, add_a: intensity_a_reg, add_b: intensity_b_reg};

    pstr_pixel_alu u_alu (
        .op        (alu_op),
        .pixel_in  (rdata_reg),
        .pixel_out (alu_out)
    );

    // framebuffer port control
    assign mem_we    = (state_reg == pstr_pkg::ST_CLEAR) || (state_reg == pstr_pkg::ST_WR);
    assign mem_re    = (state_reg == pstr_pkg::ST_RD) || (state_reg == pstr_pkg::ST_LOOKUP);
    assign mem_wdata = (state_reg == pstr_pkg::ST_CLEAR) ? '0 : alu_out;

    // framebuffer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            fb_mem_reg[addr_reg] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= fb_mem_reg[addr_reg];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intensity_a_reg <= pstr_pkg::INTENSITY_RST;
            intensity_b_reg <= pstr_pkg::INTENSITY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pstr_pkg::REG_INTENSITY_A: intensity_a_reg <= cfg_wr_data;
                pstr_pkg::REG_INTENSITY_B: intensity_b_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // item payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            prod_reg        <= PROD_W'(s_sample) * HEIGHT_S;
            frame_start_reg <= s_frame_start;
            in_range_reg    <= read_in_range;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pstr_pkg::ST_CLEAR;
            addr_reg     <= '0;
            col_reg      <= '0;
            prev_row_reg <= ROW_W'(HEIGHT / 2);
            fade_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // result transfer frees the output register unless a new pixel loads it
            if (m_valid_reg && m_ready && (state_reg != pstr_pkg::ST_RDATA)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                pstr_pkg::ST_CLEAR: begin
                    if (addr_reg == LAST_ADDR) begin
                        state_reg <= pstr_pkg::ST_IDLE;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end

                pstr_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        unique case (s_operation)
                            pstr_pkg::OP_DRAW: begin
                                fade_reg  <= 1'b0;
                                state_reg <= pstr_pkg::ST_ROW;
                            end
                            pstr_pkg::OP_FADE: begin
                                fade_reg  <= 1'b1;
                                addr_reg  <= '0;
                                state_reg <= pstr_pkg::ST_RD;
                            end
                            pstr_pkg::OP_READ: begin
                                addr_reg  <= read_in_range ?
                                    ADDR_W'(ADDR_W'(s_read_row) * ROW_STEP
                                            + ADDR_W'(s_read_column)) : '0;
                                state_reg <= pstr_pkg::ST_LOOKUP;
                            end
                            default: ;
                        endcase
                    end
                end

                // line end points and column advance
                pstr_pkg::ST_ROW: begin
                    cur_row_reg  <= (prev_eff < row_next) ? prev_eff : row_next;
                    end_row_reg  <= (prev_eff < row_next) ? row_next : prev_eff;
                    prev_row_reg <= row_next;
                    draw_col_reg <= col_eff;
                    col_reg      <= (32'(col_eff) < WIDTH) ? col_eff + 1'b1 : col_eff;
                    state_reg    <= pstr_pkg::ST_SETUP;
                end

                // first pixel address, nothing to draw past the right edge
                pstr_pkg::ST_SETUP: begin
                    if (32'(draw_col_reg) < WIDTH) begin
                        addr_reg  <= ADDR_W'(ADDR_W'(cur_row_reg) * ROW_STEP
                                             + ADDR_W'(draw_col_reg));
                        state_reg <= pstr_pkg::ST_RD;
                    end else begin
                        state_reg <= pstr_pkg::ST_IDLE;
                    end
                end

                pstr_pkg::ST_RD: begin
                    state_reg <= pstr_pkg::ST_WR;
                end

                // write back and step to the next pixel
                pstr_pkg::ST_WR: begin
                    if (fade_reg) begin
                        if (addr_reg == LAST_ADDR) begin
                            state_reg <= pstr_pkg::ST_IDLE;
                        end else begin
                            addr_reg  <= addr_reg + 1'b1;
                            state_reg <= pstr_pkg::ST_RD;
                        end
                    end else begin
                        if (cur_row_reg == end_row_reg) begin
                            state_reg <= pstr_pkg::ST_IDLE;
                        end else begin
                            cur_row_reg <= cur_row_reg + 1'b1;
                            addr_reg    <= addr_reg + ROW_STEP;
                            state_reg   <= pstr_pkg::ST_RD;
                        end
                    end
                end

                pstr_pkg::ST_LOOKUP: begin
                    state_reg <= pstr_pkg::ST_RDATA;
                end

                // load the output register once it is free
                pstr_pkg::ST_RDATA: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_pixel_value_reg <= in_range_reg ?
                            {rdata_reg[PIXEL_W-1 -: 4], rdata_reg[CH_W-1 -: 4]} : '0;
                        state_reg         <= pstr_pkg::ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= pstr_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/pstr_pixel_alu.sv
// ----------------------------------------------------------------------------
// pstr_pixel_alu
// Shared pixel unit: saturating add of both intensities for a drawn pixel,
// or the persistence decay b - (b>>4) - (b>>5) on both channels for a fade.
// ----------------------------------------------------------------------------
module pstr_pixel_alu (
    input  pstr_pkg::pixel_op_t          op,
    input  logic [pstr_pkg::PIXEL_W-1:0] pixel_in,
    output logic [pstr_pkg::PIXEL_W-1:0] pixel_out
);

    localparam int CH_W = pstr_pkg::CH_W;

    logic [CH_W-1:0] ch0, ch1;
    logic [CH_W:0]   sum0, sum1;
    logic [CH_W-1:0] draw0, draw1, fade0, fade1;

    assign ch0 = pixel_in[CH_W-1:0];
    assign ch1 = pixel_in[2*CH_W-1:CH_W];

    // saturating add
    assign sum0  = {1'b0, ch0} + {1'b0, op.add_a};
    assign sum1  = {1'b0, ch1} + {1'b0, op.add_b};
    assign draw0 = sum0[CH_W] ? {CH_W{1'b1}} : sum0[CH_W-1:0];
    assign draw1 = sum1[CH_W] ? {CH_W{1'b1}} : sum1[CH_W-1:0];

    // decay, never underflows
    assign fade0 = ch0 - (ch0 >> 4) - (ch0 >> 5);
    assign fade1 = ch1 - (ch1 >> 4) - (ch1 >> 5);

    assign pixel_out = op.fade ? {fade1, fade0} : {draw1, draw0};

endmodule
